// File: hdl/fpadd_pkg.sv
// ---------------------------------------------------------------------------
// fpadd_pkg
// Shared types and constants for the single-precision magnitude adder.
// ---------------------------------------------------------------------------
package fpadd_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned FRAC_W = 23;
    // hidden one + fraction + guard
    localparam int unsigned MANT_W = FRAC_W + 2;
    // one extra bit of headroom for the two exponent increments
    localparam int unsigned EXPX_W = EXP_W + 1;

    localparam logic [EXPX_W-1:0] EXP_INF  = EXPX_W'(255);
    localparam logic [WORD_W-1:0] INF_WORD = 32'h7F80_0000;

    // after exponent compare and operand swap
    typedef struct packed {
        logic [EXP_W-1:0]  exp;
        logic [EXP_W-1:0]  diff;
        logic [MANT_W-1:0] big_mant;
        logic [MANT_W-1:0] small_mant;
    } fpadd_cmp_t;

    // after alignment and mantissa add
    typedef struct packed {
        logic [EXP_W-1:0]  exp;
        logic [MANT_W:0]   sum;
    } fpadd_sum_t;

    // packed result
    typedef struct packed {
        logic              overflow;
        logic [WORD_W-1:0] word;
    } fpadd_res_t;

endpackage

// File: hdl/fpadd_cmp.sv
// ---------------------------------------------------------------------------
// fpadd_cmp
// Stage 1: unpack both operands, compare exponents, swap so the larger
// exponent is first and register the exponent difference.
// ---------------------------------------------------------------------------
module fpadd_cmp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  logic [fpadd_pkg::WORD_W-1:0] operand_a,
    input  logic [fpadd_pkg::WORD_W-1:0] operand_b,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output fpadd_pkg::fpadd_cmp_t       dn_data
);
    import fpadd_pkg::*;

    logic             valid_reg;
    fpadd_cmp_t       data_reg;
    fpadd_cmp_t       data_next;
    logic [EXP_W-1:0] exp_a;
    logic [EXP_W-1:0] exp_b;
    logic [MANT_W-1:0] mant_a;
    logic [MANT_W-1:0] mant_b;

    assign exp_a  = operand_a[FRAC_W +: EXP_W];
    assign exp_b  = operand_b[FRAC_W +: EXP_W];
    assign mant_a = {1'b1, operand_a[FRAC_W-1:0], 1'b0};
    assign mant_b = {1'b1, operand_b[FRAC_W-1:0], 1'b0};

    always_comb
    begin
        if (exp_a < exp_b)
        begin
            data_next.exp        = exp_b;
            data_next.diff       = exp_b - exp_a;
            data_next.big_mant   = mant_b;
            data_next.small_mant = mant_a;
        end
        else
        begin
            data_next.exp        = exp_a;
            data_next.diff       = exp_a - exp_b;
            data_next.big_mant   = mant_a;
            data_next.small_mant = mant_b;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hdl/fpadd_add.sv
// ---------------------------------------------------------------------------
// fpadd_add
// Stage 2: align the smaller mantissa by the exponent difference and add.
// ---------------------------------------------------------------------------
module fpadd_add (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  fpadd_pkg::fpadd_cmp_t up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output fpadd_pkg::fpadd_sum_t dn_data
);
    import fpadd_pkg::*;

    logic              valid_reg;
    fpadd_sum_t        data_reg;
    fpadd_sum_t        data_next;
    logic [MANT_W-1:0] aligned;

    // shifts of 25 or more clear the mantissa
    assign aligned = up_data.small_mant >> up_data.diff;

    always_comb
    begin
        data_next.exp = up_data.exp;
        data_next.sum = {1'b0, up_data.big_mant} + {1'b0, aligned};
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hdl/fpadd_rnd.sv
// ---------------------------------------------------------------------------
// fpadd_rnd
// Stage 3: normalize on carry, round half up on the guard bit, renormalize,
// clamp to infinity and pack. Its register is the output register.
// ---------------------------------------------------------------------------
module fpadd_rnd (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  fpadd_pkg::fpadd_sum_t up_data,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output fpadd_pkg::fpadd_res_t dn_data
);
    import fpadd_pkg::*;

    logic              valid_reg;
    fpadd_res_t        data_reg;
    fpadd_res_t        data_next;
    logic [MANT_W:0]   norm;
    logic [EXPX_W-1:0] exp_norm;
    logic [MANT_W:0]   rounded;
    logic [MANT_W:0]   final_mant;
    logic [EXPX_W-1:0] exp_final;

    always_comb
    begin
        if (up_data.sum[MANT_W])
        begin
            norm     = up_data.sum >> 1;
            exp_norm = {1'b0, up_data.exp} + EXPX_W'(1);
        end
        else
        begin
            norm     = up_data.sum;
            exp_norm = {1'b0, up_data.exp};
        end

        rounded = norm + {{MANT_W{1'b0}}, norm[0]};

        if (rounded[MANT_W])
        begin
            final_mant = rounded >> 1;
            exp_final  = exp_norm + EXPX_W'(1);
        end
        else
        begin
            final_mant = rounded;
            exp_final  = exp_norm;
        end

        if (exp_final >= EXP_INF)
        begin
            data_next.word     = INF_WORD;
            data_next.overflow = 1'b1;
        end
        else
        begin
            data_next.word     = {1'b0, exp_final[EXP_W-1:0], final_mant[FRAC_W:1]};
            data_next.overflow = 1'b0;
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            data_reg <= data_next;
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// File: hdl/float32_positive_adder_unit.sv
// ---------------------------------------------------------------------------
// float32_positive_adder_unit
// Adds the magnitudes of two single-precision words on a stream.
// ---------------------------------------------------------------------------
// Three-stage pipeline (exponent compare, align and add, round and pack):
// one operand pair per cycle unless stalled; each stage registers it in turn.
// Each stage holds its data while the stage after it is full and stalled, so
// back-pressure on the result side fills the empty stages before it reaches
// the input. Signs are ignored and the result sign is 0; every input is taken
// as a normal number with a hidden one. Rounding is half up on one guard bit.
// A result exponent of 255 or more returns infinity and sets the overflow flag.
module float32_positive_adder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] operand_a, [63:32] operand_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sum_word
    output logic        m_axis_tuser    // [0] exponent_overflow
);
    import fpadd_pkg::*;

    logic       cmp_valid;
    logic       cmp_ready;
    fpadd_cmp_t cmp_data;
    logic       sum_valid;
    logic       sum_ready;
    fpadd_sum_t sum_data;
    fpadd_res_t res_data;

    fpadd_cmp u_cmp (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s_axis_tvalid),
        .up_ready  (s_axis_tready),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .dn_valid  (cmp_valid),
        .dn_ready  (cmp_ready),
        .dn_data   (cmp_data)
    );

    fpadd_add u_add (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cmp_valid),
        .up_ready (cmp_ready),
        .up_data  (cmp_data),
        .dn_valid (sum_valid),
        .dn_ready (sum_ready),
        .dn_data  (sum_data)
    );

    fpadd_rnd u_rnd (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sum_valid),
        .up_ready (sum_ready),
        .up_data  (sum_data),
        .dn_valid (m_axis_tvalid),
        .dn_ready (m_axis_tready),
        .dn_data  (res_data)
    );

    assign m_axis_tdata = res_data.word;
    assign m_axis_tuser = res_data.overflow;

endmodule

// File: sim/float32_positive_adder_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// float32_positive_adder_unit_tb
// Self-checking bench for the single-precision magnitude adder. A queue-fed
// driver offers operand pairs on the input stream. Each accepted transaction
// is run through a bit-exact adder model, and the result is queued. A monitor
// checks every output transaction against the oldest queued sum. Both sides
// idle at random, and one long output stall backs the pipeline up.
// ---------------------------------------------------------------------------
module float32_positive_adder_unit_tb;

    import fpadd_pkg::*;

    typedef struct packed {
        logic [31:0] op_b;
        logic [31:0] op_a;
    } operand_pair_t;

    typedef struct packed {
        logic        overflow;
        logic [31:0] word;
    } sum_result_t;

    localparam int RANDOM_PAIRS = 900;
    localparam int IDLE_PCT     = 20;
    localparam int STALL_CYCLES = 150;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    operand_pair_t pending_pairs[$];
    sum_result_t   expected_sums[$];
    int            pairs_sent;
    int            sums_seen;
    int            error_count;
    int            stall_left;
    bit            stall_done;

    float32_positive_adder_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Align, add, renormalize, round half up on the guard bit, clamp to inf.
    function automatic sum_result_t magnitude_sum(input logic [31:0] a, input logic [31:0] b);
        logic [7:0]  exp_a;
        logic [7:0]  exp_b;
        logic [7:0]  shift;
        logic [8:0]  exp_r;
        logic [25:0] mant_a;
        logic [25:0] mant_b;
        logic [25:0] mant_r;
        sum_result_t res;
        exp_a  = a[30:23];
        exp_b  = b[30:23];
        mant_a = {2'b01, a[22:0], 1'b0};
        mant_b = {2'b01, b[22:0], 1'b0};
        if (exp_a < exp_b)
        begin
            exp_r  = {1'b0, exp_b};
            shift  = exp_b - exp_a;
            mant_a = (shift > 8'd25) ? 26'd0 : (mant_a >> shift);
        end
        else
        begin
            exp_r  = {1'b0, exp_a};
            shift  = exp_a - exp_b;
            mant_b = (shift > 8'd25) ? 26'd0 : (mant_b >> shift);
        end
        mant_r = mant_a + mant_b;
        if (mant_r[25])
        begin
            mant_r = mant_r >> 1;
            exp_r  = exp_r + 9'd1;
        end
        mant_r = mant_r + {25'd0, mant_r[0]};
        if (mant_r[25])
        begin
            mant_r = mant_r >> 1;
            exp_r  = exp_r + 9'd1;
        end
        if (exp_r >= EXP_INF)
        begin
            res.word     = INF_WORD;
            res.overflow = 1'b1;
        end
        else
        begin
            res.word     = {1'b0, exp_r[7:0], mant_r[23:1]};
            res.overflow = 1'b0;
        end
        return res;
    endfunction

    task automatic add_pair(input logic [31:0] a, input logic [31:0] b);
        operand_pair_t p;
        p.op_a = a;
        p.op_b = b;
        pending_pairs.push_back(p);
    endtask

    // Input driver: holds the transaction until taken, predicts on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            pairs_sent    <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_sums.push_back(magnitude_sum(s_axis_tdata[31:0], s_axis_tdata[63:32]));
                pairs_sent <= pairs_sent + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                // no idling while transactions 450 to 599 stream through
                if (pending_pairs.size() != 0 &&
                    ((pairs_sent >= 450 && pairs_sent < 600) ||
                     $urandom_range(99) >= IDLE_PCT))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_pairs.pop_front();
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output ready: random stalls, one long hold-off, one stall-free stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    = 0;
            stall_done    = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!stall_done && sums_seen >= 300)
        begin
            stall_done    = 1'b1;
            stall_left    = STALL_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (sums_seen >= 450 && sums_seen < 600)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: compare each output transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sums_seen   <= 0;
            error_count <= 0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            sums_seen <= sums_seen + 1;
            if (expected_sums.size() == 0)
            begin
                $display("%0t: unexpected result word=%h overflow=%b",
                         $realtime, m_axis_tdata, m_axis_tuser);
                error_count <= error_count + 1;
            end
            else
            begin
                sum_result_t exp_res;
                exp_res = expected_sums.pop_front();
                if (m_axis_tdata !== exp_res.word || m_axis_tuser !== exp_res.overflow)
                begin
                    if (m_axis_tdata !== exp_res.word)
                        $display("%0t: sum_word mismatch expected=%h actual=%h",
                                 $realtime, exp_res.word, m_axis_tdata);
                    if (m_axis_tuser !== exp_res.overflow)
                        $display("%0t: exponent_overflow mismatch expected=%b actual=%b",
                                 $realtime, exp_res.overflow, m_axis_tuser);
                    error_count <= error_count + 1;
                end
            end
        end
    end

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic [7:0]  e_base;
        int          kind;

        rst_n = 1'b0;

        // directed: extremes and the corner cases of the datapath
        add_pair(32'h0000_0000, 32'h0000_0000);   // zeros taken as 1.0 * 2^-127
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // all ones, signs set, exp 255
        add_pair(32'h7F80_0000, 32'h0000_0000);   // infinity input
        add_pair(32'h7FC0_0000, 32'h3F80_0000);   // NaN input
        add_pair(32'h0000_0001, 32'h0000_0001);   // subnormals
        add_pair(32'h007F_FFFF, 32'h007F_FFFF);   // max fraction, min exponent
        add_pair(32'h3F80_0000, 32'h3F80_0000);   // sum carry
        add_pair(32'hBF80_0000, 32'h3F80_0000);   // sign ignored
        add_pair(32'h3FFF_FFFF, 32'h3380_0000);   // rounding carry
        add_pair(32'h3380_0000, 32'h3FFF_FFFF);   // same, swapped
        add_pair(32'h3F80_0000, 32'h3300_0000);   // exponent gap 25
        add_pair(32'h3F80_0000, 32'h3280_0000);   // exponent gap 26
        add_pair(32'h3280_0000, 32'h3F80_0000);   // gap 26, b larger
        add_pair(32'h3F80_0001, 32'h3400_0000);   // exponent gap 23, guard clear after align
        add_pair(32'h7F00_0000, 32'h0000_0000);   // huge gap
        add_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);   // overflow from sum carry
        add_pair(32'h7F7F_FFFF, 32'h7300_0000);   // overflow from rounding
        add_pair(32'h7F00_0000, 32'h7E80_0000);   // exponent 254 without overflow
        add_pair(32'h8000_0000, 32'h7FFF_FFFF);
        add_pair(32'hAAAA_AAAA, 32'h5555_5555);
        add_pair(32'h5555_5555, 32'hAAAA_AAAA);

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            kind = $urandom_range(9);
            a    = $urandom;
            b    = $urandom;
            if (kind < 6)
            begin
                // close exponents: the alignment and rounding paths
                e_base = $urandom_range(255);
                a[30:23] = e_base;
                b[30:23] = e_base + 8'($urandom_range(28)) - 8'($urandom_range(28));
            end
            else if (kind == 6)
            begin
                // near the top of the range
                a[30:23] = 8'($urandom_range(255, 250));
                b[30:23] = 8'($urandom_range(255, 240));
            end
            else if (kind == 7)
            begin
                // fractions near all ones to provoke rounding carries
                a[22:0] = 23'h7F_FFFF ^ 23'($urandom_range(3));
                b[30:23] = a[30:23] - 8'($urandom_range(26, 20));
            end
            add_pair(a, b);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pairs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hdl/fpadd_pkg.sv
hdl/fpadd_cmp.sv
hdl/fpadd_add.sv
hdl/fpadd_rnd.sv
hdl/float32_positive_adder_unit.sv
sim/float32_positive_adder_unit_tb.sv
